### src/tmg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmg_pkg
// Shared types, constants and helper functions of the texel mask generator.
// ----------------------------------------------------------------------------
package tmg_pkg;

    localparam int ONE          = 65536;
    localparam int SAMPLE_W     = 21;
    localparam int MASK_W       = 17;
    localparam int CFG_W        = 24;
    localparam int CFG_ADDR_W   = 3;
    localparam int S_TDATA_W    = 168;
    localparam int M_TDATA_W    = 24;
    localparam int DIV_STAGES   = 8;
    localparam int DIV_STEPS    = 2;
    localparam int LOG_STAGES   = 16;
    localparam int EXP_STAGES   = 16;

    typedef enum logic [2:0] {
        MODE_OCCLUSION,
        MODE_CURVATURE,
        MODE_THICKNESS,
        MODE_POSITION,
        MODE_DIRECTION,
        MODE_DIRT,
        MODE_EDGE,
        MODE_SCRATCH
    } mode_t;

    typedef enum logic [2:0] {
        CFG_MODE,
        CFG_STRENGTH,
        CFG_CONTRAST,
        CFG_CONCAVITY,
        CFG_WEAR,
        CFG_FREQUENCY,
        CFG_HALF_WIDTH
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_EDGE,
        KIND_SCRATCH
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        force_zero;
        logic        force_full;
        logic [16:0] b_direct;
        logic [16:0] graze;
    } div_side_t;

    function automatic logic [16:0] clamp_unit(input logic signed [39:0] v);
        if (v < 40'sd0) begin
            return 17'd0;
        end else if (v > 40'sd65536) begin
            return 17'd65536;
        end
        return v[16:0];
    endfunction

    // Q30 root 2^(-2^-k), formed by repeated integer square roots
    function automatic logic [30:0] exp_root(input int k);
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        r = 64'd1 << 29;
        for (int i = 1; i <= k; i++) begin
            v   = r << 30;
            res = '0;
            bt  = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (v >= res + bt) begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            r = res;
        end
        return r[30:0];
    endfunction

endpackage
`default_nettype wire

### src/tmg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmg_div
// Pipelined restoring divider: q = floor(num * 2^16 / den) for num < den,
// two quotient bits per stage, with sideband carried alongside.
// ----------------------------------------------------------------------------
module tmg_div import tmg_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [15:0] in_num,
    input  wire logic [16:0] in_den,
    input  wire div_side_t   in_side,
    output logic             out_valid,
    output logic [15:0]      out_quo,
    output div_side_t        out_side
);

    logic        vld_reg  [DIV_STAGES];
    logic [15:0] rem_reg  [DIV_STAGES];
    logic [16:0] den_reg  [DIV_STAGES];
    logic [15:0] quo_reg  [DIV_STAGES];
    div_side_t   side_reg [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic        vld_prev;
        logic [15:0] rem_prev;
        logic [16:0] den_prev;
        logic [15:0] quo_prev;
        div_side_t   side_prev;
        logic [15:0] rem_next;
        logic [15:0] quo_next;

        if (g == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = in_num;
            assign den_prev  = in_den;
            assign quo_prev  = '0;
            assign side_prev = in_side;
        end else begin : g_rest
            assign vld_prev  = vld_reg[g-1];
            assign rem_prev  = rem_reg[g-1];
            assign den_prev  = den_reg[g-1];
            assign quo_prev  = quo_reg[g-1];
            assign side_prev = side_reg[g-1];
        end

        always_comb begin
            logic [16:0] r2;
            rem_next = rem_prev;
            quo_next = quo_prev;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r2 = {rem_next, 1'b0};
                if (r2 >= den_prev) begin
                    rem_next = 16'(r2 - den_prev);
                    quo_next = {quo_next[14:0], 1'b1};
                end else begin
                    rem_next = r2[15:0];
                    quo_next = {quo_next[14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= rem_next;
                den_reg[g]  <= den_prev;
                quo_reg[g]  <= quo_next;
                side_reg[g] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_quo   = quo_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

### src/tmg_pow.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmg_pow
// Contrast shaping b^contrast: normalize, sixteen squaring stages for the
// log2 fraction, one scale multiply, sixteen root multiply stages for exp2.
// ----------------------------------------------------------------------------
module tmg_pow import tmg_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic [18:0] contrast,
    input  wire logic        in_valid,
    input  wire logic [16:0] in_b,
    output logic             out_valid,
    output logic [16:0]      out_shaped
);

    // normalize stage
    logic        nv_reg;
    logic        nbyp_reg;
    logic [16:0] nval_reg;
    logic [16:0] nm_reg;
    logic [4:0]  ns_reg;
    logic        nbyp_next;
    logic [16:0] nval_next;
    logic [16:0] nm_next;
    logic [4:0]  ns_next;

    always_comb begin
        logic [4:0]  msb;
        logic [32:0] sh;
        msb = '0;
        for (int i = 0; i < 16; i++) begin
            if (in_b[i]) begin
                msb = 5'(i);
            end
        end
        ns_next   = 5'd16 - msb;
        sh        = 33'(in_b) << ns_next;
        nm_next   = sh[16:0];
        nbyp_next = 1'b1;
        nval_next = 17'(ONE);
        if (contrast == 19'(ONE)) begin
            nval_next = in_b;
        end else if (contrast == 19'd0) begin
            nval_next = 17'(ONE);
        end else if (in_b == 17'd0) begin
            nval_next = 17'd0;
        end else if (in_b >= 17'(ONE)) begin
            nval_next = 17'(ONE);
        end else begin
            nbyp_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg <= 1'b0;
        end else if (en) begin
            nv_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nbyp_reg <= nbyp_next;
            nval_reg <= nval_next;
            nm_reg   <= nm_next;
            ns_reg   <= ns_next;
        end
    end

    // log2 squaring stages
    logic        lv_reg   [LOG_STAGES];
    logic        lbyp_reg [LOG_STAGES];
    logic [16:0] lval_reg [LOG_STAGES];
    logic [16:0] lm_reg   [LOG_STAGES];
    logic [4:0]  ls_reg   [LOG_STAGES];
    logic [15:0] lf_reg   [LOG_STAGES];

    for (genvar g = 0; g < LOG_STAGES; g++) begin : g_log
        logic        v_prev;
        logic        byp_prev;
        logic [16:0] val_prev;
        logic [16:0] m_prev;
        logic [4:0]  s_prev;
        logic [15:0] f_prev;
        logic [33:0] sq;
        logic [16:0] m_next;
        logic [15:0] f_next;

        if (g == 0) begin : g_first
            assign v_prev   = nv_reg;
            assign byp_prev = nbyp_reg;
            assign val_prev = nval_reg;
            assign m_prev   = nm_reg;
            assign s_prev   = ns_reg;
            assign f_prev   = '0;
        end else begin : g_rest
            assign v_prev   = lv_reg[g-1];
            assign byp_prev = lbyp_reg[g-1];
            assign val_prev = lval_reg[g-1];
            assign m_prev   = lm_reg[g-1];
            assign s_prev   = ls_reg[g-1];
            assign f_prev   = lf_reg[g-1];
        end

        assign sq     = 34'(m_prev) * 34'(m_prev);
        assign m_next = sq[33] ? sq[33:17] : sq[32:16];
        assign f_next = {f_prev[14:0], sq[33]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                lv_reg[g] <= 1'b0;
            end else if (en) begin
                lv_reg[g] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                lbyp_reg[g] <= byp_prev;
                lval_reg[g] <= val_prev;
                lm_reg[g]   <= m_next;
                ls_reg[g]   <= s_prev;
                lf_reg[g]   <= f_next;
            end
        end
    end

    // scale by contrast
    logic        xv_reg;
    logic        xbyp_reg;
    logic [16:0] xval_reg;
    logic [7:0]  xn_reg;
    logic [15:0] xfr_reg;
    logic [20:0] log_a;
    logic [39:0] scaled;

    assign log_a  = 21'({ls_reg[LOG_STAGES-1], 16'b0}) - 21'(lf_reg[LOG_STAGES-1]);
    assign scaled = 40'(log_a) * 40'(contrast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xv_reg <= 1'b0;
        end else if (en) begin
            xv_reg <= lv_reg[LOG_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xbyp_reg <= lbyp_reg[LOG_STAGES-1];
            xval_reg <= lval_reg[LOG_STAGES-1];
            xn_reg   <= scaled[39:32];
            xfr_reg  <= scaled[31:16];
        end
    end

    // exp2 root stages
    logic        ev_reg   [EXP_STAGES];
    logic        ebyp_reg [EXP_STAGES];
    logic [16:0] eval_reg [EXP_STAGES];
    logic [7:0]  en_reg   [EXP_STAGES];
    logic [15:0] efr_reg  [EXP_STAGES];
    logic [30:0] eg_reg   [EXP_STAGES];

    for (genvar g = 0; g < EXP_STAGES; g++) begin : g_exp
        localparam logic [30:0] ROOT = exp_root(g + 1);
        logic        v_prev;
        logic        byp_prev;
        logic [16:0] val_prev;
        logic [7:0]  n_prev;
        logic [15:0] fr_prev;
        logic [30:0] g_prev;
        logic [61:0] prod;
        logic [30:0] g_next;

        if (g == 0) begin : g_first
            assign v_prev   = xv_reg;
            assign byp_prev = xbyp_reg;
            assign val_prev = xval_reg;
            assign n_prev   = xn_reg;
            assign fr_prev  = xfr_reg;
            assign g_prev   = 31'd1 << 30;
        end else begin : g_rest
            assign v_prev   = ev_reg[g-1];
            assign byp_prev = ebyp_reg[g-1];
            assign val_prev = eval_reg[g-1];
            assign n_prev   = en_reg[g-1];
            assign fr_prev  = efr_reg[g-1];
            assign g_prev   = eg_reg[g-1];
        end

        assign prod   = 62'(g_prev) * 62'(ROOT);
        assign g_next = fr_prev[EXP_STAGES-1-g] ? prod[60:30] : g_prev;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ev_reg[g] <= 1'b0;
            end else if (en) begin
                ev_reg[g] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ebyp_reg[g] <= byp_prev;
                eval_reg[g] <= val_prev;
                en_reg[g]   <= n_prev;
                efr_reg[g]  <= fr_prev;
                eg_reg[g]   <= g_next;
            end
        end
    end

    // final shift
    logic        yv_reg;
    logic [16:0] yshaped_reg;
    logic [16:0] yshaped_next;
    logic [8:0]  shamt;
    logic [30:0] shifted;

    assign shamt   = 9'd14 + 9'(en_reg[EXP_STAGES-1]);
    assign shifted = eg_reg[EXP_STAGES-1] >> shamt;

    always_comb begin
        if (ebyp_reg[EXP_STAGES-1]) begin
            yshaped_next = eval_reg[EXP_STAGES-1];
        end else if (en_reg[EXP_STAGES-1] > 8'd40) begin
            yshaped_next = '0;
        end else begin
            yshaped_next = shifted[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yv_reg <= 1'b0;
        end else if (en) begin
            yv_reg <= ev_reg[EXP_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            yshaped_reg <= yshaped_next;
        end
    end

    assign out_valid  = yv_reg;
    assign out_shaped = yshaped_reg;

endmodule
`default_nettype wire

### src/texel_mask_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// texel_mask_generator
// Per-texel mask value from sampled mesh-map values, one of eight generators,
// followed by contrast power and strength scaling.
//
//   port group   dir   payload (low bit first)
//   s_*          in    occlusion, curvature, thickness, pos x/y/z, dir y/z
//   m_*          out   mask_value
//   cfg_*        in    register index and data, no read-back
//
// One texel per cycle while the output is not stalled on m_tready.
// The path runs through stages A and B, the 8-stage divider, stage C, the
// 16 squaring plus 16 root-multiply stages of the power unit and the output register.
// Reset clears valid bits and loads the register defaults.
// A stall on m_tready freezes the whole pipeline; s_tready drops with it.
// ----------------------------------------------------------------------------
module texel_mask_generator import tmg_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // occlusion_sample, curvature_sample, thickness_sample, position_x,
    // position_y, position_z, direction_y, direction_z (21 bits each)
    input  wire logic [S_TDATA_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // mask_value (17 bits), zero padded
    output logic [M_TDATA_W-1:0]         m_tdata,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [CFG_W-1:0]        cfg_data
);

    // configuration registers
    mode_t       mode_reg;
    logic [17:0] strength_reg;
    logic [18:0] contrast_reg;
    logic [16:0] concavity_reg;
    logic [15:0] wear_reg;
    logic [23:0] freq_reg;
    logic [14:0] half_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_OCCLUSION;
            strength_reg   <= 18'(ONE);
            contrast_reg   <= 19'(ONE);
            concavity_reg  <= 17'(ONE);
            wear_reg       <= 16'd32768;
            freq_reg       <= 24'(ONE);
            half_width_reg <= 15'd2731;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MODE:       mode_reg       <= mode_t'(cfg_data[2:0]);
                CFG_STRENGTH:   strength_reg   <= cfg_data[17:0];
                CFG_CONTRAST:   contrast_reg   <= cfg_data[18:0];
                CFG_CONCAVITY:  concavity_reg  <= cfg_data[16:0];
                CFG_WEAR:       wear_reg       <= cfg_data[15:0];
                CFG_FREQUENCY:  freq_reg       <= cfg_data[23:0];
                CFG_HALF_WIDTH: half_width_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic m_tvalid_reg;
    logic [16:0] mask_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // stage A: unpack, dirt product, phase sum, graze
    logic signed [20:0] occ, curv, thick, px, py, pz, dy, dz;
    assign occ   = $signed(s_tdata[20:0]);
    assign curv  = $signed(s_tdata[41:21]);
    assign thick = $signed(s_tdata[62:42]);
    assign px    = $signed(s_tdata[83:63]);
    assign py    = $signed(s_tdata[104:84]);
    assign pz    = $signed(s_tdata[125:105]);
    assign dy    = $signed(s_tdata[146:126]);
    assign dz    = $signed(s_tdata[167:147]);

    logic               va_reg;
    logic signed [22:0] occ_inv_a_reg;
    logic signed [22:0] thick_inv_a_reg;
    logic signed [20:0] curv_a_reg;
    logic signed [20:0] py_a_reg;
    logic signed [20:0] dy_a_reg;
    logic signed [39:0] dirt_a_reg;
    logic signed [26:0] sum_a_reg;
    logic [16:0]        graze_a_reg;

    logic signed [21:0] conc;
    logic signed [22:0] tz;
    logic signed [22:0] tz_abs;

    assign conc   = 22'sd32768 - 22'(curv);
    assign tz     = (23'(dz) <<< 1) - 23'sd65536;
    assign tz_abs = (tz < 23'sd0) ? -tz : tz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            occ_inv_a_reg   <= 23'sd65536 - 23'(occ);
            thick_inv_a_reg <= 23'sd65536 - 23'(thick);
            curv_a_reg      <= curv;
            py_a_reg        <= py;
            dy_a_reg        <= dy;
            dirt_a_reg      <= 40'(conc) * $signed({23'b0, concavity_reg});
            sum_a_reg       <= 27'(px) * 27'sd31 + 27'(py) * 27'sd7 + 27'(pz) * 27'sd13;
            graze_a_reg     <= clamp_unit(40'(23'sd65536 - tz_abs));
        end
    end

    // stage B: phase, dirt max, generator select, divider operands
    logic        vb_reg;
    logic [15:0] num_b_reg;
    logic [16:0] den_b_reg;
    div_side_t   side_b_reg;

    logic [15:0] num_b_next;
    logic [16:0] den_b_next;
    div_side_t   side_b_next;

    always_comb begin
        logic [31:0]        phase;
        logic [15:0]        frac;
        logic [15:0]        frac_dev;
        logic [14:0]        hw;
        logic signed [39:0] dirt_c;
        logic signed [39:0] dirt_a;
        logic signed [21:0] curv_rel;
        phase    = 32'(sum_a_reg) * 32'(freq_reg);
        frac     = phase[31:16];
        frac_dev = (frac >= 16'd32768) ? frac - 16'd32768 : 16'd32768 - frac;
        hw       = (half_width_reg == 15'd0) ? 15'd1 : half_width_reg;
        dirt_c   = dirt_a_reg >>> 15;
        dirt_a   = 40'(occ_inv_a_reg);
        curv_rel = 22'(curv_a_reg) - $signed({6'b0, wear_reg});

        num_b_next             = '0;
        den_b_next             = 17'(ONE);
        side_b_next.kind       = KIND_DIRECT;
        side_b_next.force_zero = 1'b0;
        side_b_next.force_full = 1'b0;
        side_b_next.b_direct   = '0;
        side_b_next.graze      = graze_a_reg;

        unique case (mode_reg)
            MODE_OCCLUSION: side_b_next.b_direct = clamp_unit(40'(occ_inv_a_reg));
            MODE_CURVATURE: side_b_next.b_direct = clamp_unit(40'(curv_a_reg));
            MODE_THICKNESS: side_b_next.b_direct = clamp_unit(40'(thick_inv_a_reg));
            MODE_POSITION:  side_b_next.b_direct = clamp_unit(40'(py_a_reg));
            MODE_DIRECTION: side_b_next.b_direct = clamp_unit(40'(dy_a_reg));
            MODE_DIRT: begin
                side_b_next.b_direct = clamp_unit((dirt_a > dirt_c) ? dirt_a : dirt_c);
            end
            MODE_EDGE: begin
                side_b_next.kind       = KIND_EDGE;
                side_b_next.force_zero = (curv_rel <= 22'sd0);
                side_b_next.force_full = (curv_a_reg >= 21'sd65536);
                num_b_next             = curv_rel[15:0];
                den_b_next             = 17'(ONE) - 17'(wear_reg);
            end
            MODE_SCRATCH: begin
                side_b_next.kind       = KIND_SCRATCH;
                side_b_next.force_zero = (frac_dev >= 16'(hw));
                num_b_next             = frac_dev;
                den_b_next             = 17'(hw);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_b_reg  <= num_b_next;
            den_b_reg  <= den_b_next;
            side_b_reg <= side_b_next;
        end
    end

    // divider
    logic        div_valid;
    logic [15:0] div_quo;
    div_side_t   div_side;

    tmg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vb_reg),
        .in_num    (num_b_reg),
        .in_den    (den_b_reg),
        .in_side   (side_b_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // stage C: edge and scratch values, direct values passed through
    logic        vc_reg;
    logic [16:0] b_c_reg;
    logic [16:0] b_c_next;

    always_comb begin
        logic [16:0] line;
        logic [33:0] lg;
        line = div_side.force_zero ? 17'd0 : 17'(ONE) - 17'(div_quo);
        lg   = 34'(line) * 34'(div_side.graze);
        unique case (div_side.kind)
            KIND_EDGE: begin
                if (div_side.force_zero) begin
                    b_c_next = '0;
                end else if (div_side.force_full) begin
                    b_c_next = 17'(ONE);
                end else begin
                    b_c_next = 17'(div_quo);
                end
            end
            KIND_SCRATCH: b_c_next = lg[32:16];
            default:      b_c_next = div_side.b_direct;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_c_reg <= b_c_next;
        end
    end

    // contrast power
    logic        pow_valid;
    logic [16:0] pow_shaped;

    tmg_pow u_pow (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .contrast   (contrast_reg),
        .in_valid   (vc_reg),
        .in_b       (b_c_reg),
        .out_valid  (pow_valid),
        .out_shaped (pow_shaped)
    );

    // strength and output register
    logic [34:0] scaled;
    logic [16:0] mask_next;

    assign scaled    = 35'(pow_shaped) * 35'(strength_reg);
    assign mask_next = (scaled[34:16] > 19'(ONE)) ? 17'(ONE) : scaled[32:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= pow_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mask_reg <= mask_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(mask_reg);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16:0] <= 17'(ONE)))
        else $error("mask above one");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> (contrast_reg == 19'(ONE) && strength_reg == 18'(ONE)))
        else $error("register defaults missing after reset");

endmodule
`default_nettype wire
